### rtl/least_loaded_job_dispatcher_assert.svh
// Assertion macros for the least-loaded job dispatcher.
// Included by the module that checks its own control logic; needs no package.
`ifndef LEAST_LOADED_JOB_DISPATCHER_ASSERT_SVH
`define LEAST_LOADED_JOB_DISPATCHER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LLJD_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dispatcher check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define LLJD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dispatcher check failed");

`endif

### rtl/lljd_pkg.sv
// Shared constants, datapath operation codes and control/status structs
// for the least-loaded job dispatcher. No dependencies.
package lljd_pkg;

  localparam int NUM_SERVERS_DEF = 8;
  localparam int LOAD_BITS_DEF   = 16;

  localparam int SID_W    = 3;
  localparam int WORK_W   = 8;
  localparam int OUT_W    = 16;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REFUSED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SUBMIT,
    OP_REFUSE_SUB,
    OP_BAD_ID,
    OP_REFUSE_DIS,
    OP_DIS_START,
    OP_GIVE,
    OP_DIS_DONE,
    OP_EN_START,
    OP_TAKE,
    OP_EN_DONE
  } dp_op_e;

  typedef struct packed {
    logic   capture;
    logic   scan_clr;
    logic   scan_rd;
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic req_type;
    logic sid_bad;
    logic sid_en;
    logic scan_last;
    logic found;
    logic min_full;
    logic max_zero;
    logic min_le_self;
    logic cnt_zero;
  } dp_sts_t;

endpackage

### rtl/lljd_dp.sv
// Datapath of the dispatcher: request registers, load memory, enable bits,
// scan accumulators, move counters and the result register. Uses lljd_pkg.
module lljd_dp #(
  parameter int NUM_SERVERS = lljd_pkg::NUM_SERVERS_DEF,
  parameter int LOAD_BITS   = lljd_pkg::LOAD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_type_i,
  input  logic [lljd_pkg::SID_W-1:0]      server_id_i,
  input  logic [lljd_pkg::WORK_W-1:0]     work_units_i,
  input  lljd_pkg::dp_cmd_t               cmd_i,
  output lljd_pkg::dp_sts_t               sts_o,
  output logic [lljd_pkg::SID_W-1:0]      chosen_server_o,
  output logic [lljd_pkg::OUT_W-1:0]      load_after_o,
  output logic [lljd_pkg::OUT_W-1:0]      units_moved_o,
  output logic                            now_enabled_o,
  output logic [lljd_pkg::STATUS_W-1:0]   status_o
);
  import lljd_pkg::*;

  localparam int IDX_W = $clog2(NUM_SERVERS);
  localparam logic [LOAD_BITS-1:0] LOAD_MAX = '1;

  // Request registers.
  logic                 req_type_q;
  logic [SID_W-1:0]     sid_q;
  logic [WORK_W-1:0]    work_q;
  logic [IDX_W-1:0]     sid_idx;

  // Load memory with per-entry valid bits; an unwritten entry reads as zero.
  logic [LOAD_BITS-1:0]   load_mem [NUM_SERVERS];
  logic [NUM_SERVERS-1:0] lv_q;
  logic [NUM_SERVERS-1:0] en_q;

  logic                 we;
  logic [IDX_W-1:0]     waddr;
  logic [LOAD_BITS-1:0] wdata;
  logic                 en_clr;
  logic                 en_set;

  // Scan pipeline.
  logic [IDX_W-1:0]     idx_q;
  logic                 rd_vld_q;
  logic [IDX_W-1:0]     rd_idx_q;
  logic                 rd_lv_q;
  logic [LOAD_BITS-1:0] rd_mem_q;
  logic [LOAD_BITS-1:0] rdata;
  logic                 peer;

  // Accumulators.
  logic                 found_q;
  logic                 zero_q;
  logic [IDX_W-1:0]     zero_idx_q;
  logic [LOAD_BITS-1:0] min_val_q;
  logic [IDX_W-1:0]     min_idx_q;
  logic [LOAD_BITS-1:0] max_val_q;
  logic [IDX_W-1:0]     max_idx_q;
  logic [LOAD_BITS-1:0] self_q;
  logic [IDX_W-1:0]     tgt_idx;

  // Move counters.
  logic [LOAD_BITS-1:0] cnt_q, cnt_d;
  logic [LOAD_BITS-1:0] moved_q, moved_d;

  logic [LOAD_BITS:0]   sub_sum;
  logic [LOAD_BITS-1:0] sub_sat;

  // Result register.
  logic                 res_ld;
  logic [SID_W-1:0]     res_chosen_d, res_chosen_q;
  logic [OUT_W-1:0]     res_load_d, res_load_q;
  logic [OUT_W-1:0]     res_moved_d, res_moved_q;
  logic                 res_en_d, res_en_q;
  logic [STATUS_W-1:0]  res_status_d, res_status_q;

  assign sid_idx = IDX_W'(sid_q);
  assign rdata   = rd_lv_q ? rd_mem_q : '0;
  assign peer    = en_q[rd_idx_q] && !(req_type_q && (rd_idx_q == sid_idx));
  assign tgt_idx = zero_q ? zero_idx_q : min_idx_q;
  assign sub_sum = {1'b0, min_val_q} + (LOAD_BITS+1)'(work_q);
  assign sub_sat = sub_sum[LOAD_BITS] ? LOAD_MAX : sub_sum[LOAD_BITS-1:0];

  always_comb begin
    sts_o.req_type    = req_type_q;
    sts_o.sid_bad     = int'(sid_q) >= NUM_SERVERS;
    sts_o.sid_en      = en_q[sid_idx];
    sts_o.scan_last   = idx_q == IDX_W'(NUM_SERVERS - 1);
    sts_o.found       = found_q;
    sts_o.min_full    = !found_q || (min_val_q == LOAD_MAX);
    sts_o.max_zero    = !found_q || (max_val_q == '0);
    sts_o.min_le_self = min_val_q <= self_q;
    sts_o.cnt_zero    = cnt_q == '0;
  end

  always_comb begin
    we           = 1'b0;
    waddr        = sid_idx;
    wdata        = '0;
    en_clr       = 1'b0;
    en_set       = 1'b0;
    cnt_d        = cnt_q;
    moved_d      = moved_q;
    res_ld       = 1'b0;
    res_chosen_d = sid_q;
    res_load_d   = '0;
    res_moved_d  = '0;
    res_en_d     = 1'b0;
    res_status_d = ST_OK;
    if (cmd_i.capture) begin
      cnt_d   = '0;
      moved_d = '0;
    end
    unique case (cmd_i.op)
      OP_NONE: begin
      end
      OP_SUBMIT: begin
        we           = 1'b1;
        waddr        = tgt_idx;
        wdata        = sub_sat;
        res_ld       = 1'b1;
        res_chosen_d = SID_W'(tgt_idx);
        res_load_d   = OUT_W'(sub_sat);
        res_en_d     = 1'b1;
        res_status_d = sub_sum[LOAD_BITS] ? ST_SATURATED : ST_OK;
      end
      OP_REFUSE_SUB: begin
        res_ld       = 1'b1;
        res_chosen_d = '0;
        res_status_d = ST_REFUSED;
      end
      OP_BAD_ID: begin
        res_ld       = 1'b1;
        res_status_d = ST_BAD_INDEX;
      end
      OP_REFUSE_DIS: begin
        res_ld       = 1'b1;
        res_load_d   = OUT_W'(self_q);
        res_en_d     = 1'b1;
        res_status_d = ST_REFUSED;
      end
      OP_DIS_START: begin
        we      = 1'b1;
        wdata   = '0;
        en_clr  = 1'b1;
        cnt_d   = self_q;
        moved_d = '0;
      end
      OP_GIVE: begin
        we      = 1'b1;
        waddr   = tgt_idx;
        wdata   = min_val_q + LOAD_BITS'(1);
        cnt_d   = cnt_q - LOAD_BITS'(1);
        moved_d = moved_q + LOAD_BITS'(1);
      end
      OP_DIS_DONE: begin
        res_ld       = 1'b1;
        res_moved_d  = OUT_W'(moved_q);
        res_status_d = (cnt_q != '0) ? ST_SATURATED : ST_OK;
      end
      OP_EN_START: begin
        cnt_d   = min_val_q;
        moved_d = min_val_q;
      end
      OP_TAKE: begin
        we    = 1'b1;
        waddr = max_idx_q;
        wdata = max_val_q - LOAD_BITS'(1);
        cnt_d = cnt_q - LOAD_BITS'(1);
      end
      OP_EN_DONE: begin
        we          = 1'b1;
        wdata       = moved_q;
        en_set      = 1'b1;
        res_ld      = 1'b1;
        res_load_d  = OUT_W'(moved_q);
        res_moved_d = OUT_W'(moved_q);
        res_en_d    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      load_mem[waddr] <= wdata;
    end
    rd_mem_q <= load_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sid_q  <= server_id_i;
      work_q <= work_units_i;
    end
    if (res_ld) begin
      res_chosen_q <= res_chosen_d;
      res_load_q   <= res_load_d;
      res_moved_q  <= res_moved_d;
      res_en_q     <= res_en_d;
      res_status_q <= res_status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_type_q <= 1'b0;
      lv_q       <= '0;
      en_q       <= '1;
      idx_q      <= '0;
      rd_vld_q   <= 1'b0;
      rd_idx_q   <= '0;
      rd_lv_q    <= 1'b0;
      found_q    <= 1'b0;
      zero_q     <= 1'b0;
      zero_idx_q <= '0;
      min_val_q  <= '0;
      min_idx_q  <= '0;
      max_val_q  <= '0;
      max_idx_q  <= '0;
      self_q     <= '0;
      cnt_q      <= '0;
      moved_q    <= '0;
    end else begin
      cnt_q   <= cnt_d;
      moved_q <= moved_d;
      if (cmd_i.capture) begin
        req_type_q <= req_type_i;
      end
      if (we) begin
        lv_q[waddr] <= 1'b1;
      end
      if (en_clr) begin
        en_q[sid_idx] <= 1'b0;
      end else if (en_set) begin
        en_q[sid_idx] <= 1'b1;
      end
      rd_vld_q <= cmd_i.scan_rd;
      rd_idx_q <= idx_q;
      rd_lv_q  <= lv_q[idx_q];
      if (cmd_i.scan_clr) begin
        idx_q   <= '0;
        found_q <= 1'b0;
        zero_q  <= 1'b0;
      end else begin
        if (cmd_i.scan_rd) begin
          idx_q <= idx_q + IDX_W'(1);
        end
        if (rd_vld_q) begin
          if (peer) begin
            found_q <= 1'b1;
            // Ties go to the higher index for both extremes.
            if (!found_q || rdata <= min_val_q) begin
              min_val_q <= rdata;
              min_idx_q <= rd_idx_q;
            end
            if (!found_q || rdata >= max_val_q) begin
              max_val_q <= rdata;
              max_idx_q <= rd_idx_q;
            end
            if (!zero_q && rdata == '0) begin
              zero_q     <= 1'b1;
              zero_idx_q <= rd_idx_q;
            end
          end
          if (rd_idx_q == sid_idx) begin
            self_q <= rdata;
          end
        end
      end
    end
  end

  assign chosen_server_o = res_chosen_q;
  assign load_after_o    = res_load_q;
  assign units_moved_o   = res_moved_q;
  assign now_enabled_o   = res_en_q;
  assign status_o        = res_status_q;

endmodule

### rtl/lljd_ctrl.sv
// Controller of the dispatcher: sequences scans, unit moves and result
// hand-off. Uses lljd_pkg and the assertion macro header.
`include "least_loaded_job_dispatcher_assert.svh"

module lljd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  lljd_pkg::dp_sts_t sts_i,
  output lljd_pkg::dp_cmd_t cmd_o
);
  import lljd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_TAIL  = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_CHECK = 3'd5;

  localparam logic [2:0] PH_SUB   = 3'd0;
  localparam logic [2:0] PH_DIS0  = 3'd1;
  localparam logic [2:0] PH_HAND  = 3'd2;
  localparam logic [2:0] PH_EN0   = 3'd3;
  localparam logic [2:0] PH_DRAIN = 3'd4;

  logic [2:0] state_q, state_d;
  logic [2:0] phase_q, phase_d;
  logic       out_vld_q, out_vld_d;
  logic       out_free;
  logic       fin;

  assign out_free    = !out_vld_q || !out_stall_i;
  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_vld_q;

  always_comb begin
    state_d        = state_q;
    phase_d        = phase_q;
    cmd_o.capture  = 1'b0;
    cmd_o.scan_clr = 1'b0;
    cmd_o.scan_rd  = 1'b0;
    cmd_o.op       = OP_NONE;
    fin            = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISP;
        end
      end
      S_DISP: begin
        priority if (!sts_i.req_type) begin
          phase_d        = PH_SUB;
          cmd_o.scan_clr = 1'b1;
          state_d        = S_SCAN;
        end else if (sts_i.sid_bad) begin
          if (out_free) begin
            cmd_o.op = OP_BAD_ID;
            fin      = 1'b1;
          end
        end else begin
          phase_d        = sts_i.sid_en ? PH_DIS0 : PH_EN0;
          cmd_o.scan_clr = 1'b1;
          state_d        = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        unique case (phase_q)
          PH_SUB: begin
            if (out_free) begin
              cmd_o.op = sts_i.found ? OP_SUBMIT : OP_REFUSE_SUB;
              fin      = 1'b1;
            end
          end
          PH_DIS0: begin
            if (!sts_i.found) begin
              if (out_free) begin
                cmd_o.op = OP_REFUSE_DIS;
                fin      = 1'b1;
              end
            end else begin
              cmd_o.op = OP_DIS_START;
              phase_d  = PH_HAND;
              state_d  = S_CHECK;
            end
          end
          PH_HAND: begin
            if (sts_i.min_full) begin
              if (out_free) begin
                cmd_o.op = OP_DIS_DONE;
                fin      = 1'b1;
              end
            end else begin
              cmd_o.op = OP_GIVE;
              state_d  = S_CHECK;
            end
          end
          PH_EN0: begin
            if (!sts_i.found || sts_i.min_le_self) begin
              if (out_free) begin
                cmd_o.op = OP_EN_DONE;
                fin      = 1'b1;
              end
            end else begin
              cmd_o.op = OP_EN_START;
              phase_d  = PH_DRAIN;
              state_d  = S_CHECK;
            end
          end
          PH_DRAIN: begin
            if (sts_i.max_zero) begin
              if (out_free) begin
                cmd_o.op = OP_EN_DONE;
                fin      = 1'b1;
              end
            end else begin
              cmd_o.op = OP_TAKE;
              state_d  = S_CHECK;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_CHECK: begin
        if (sts_i.cnt_zero) begin
          if (out_free) begin
            cmd_o.op = (phase_q == PH_HAND) ? OP_DIS_DONE : OP_EN_DONE;
            fin      = 1'b1;
          end
        end else begin
          cmd_o.scan_clr = 1'b1;
          state_d        = S_SCAN;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (fin) begin
      state_d = S_IDLE;
    end
  end

  always_comb begin
    if (fin) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= PH_SUB;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      out_vld_q <= out_vld_d;
    end
  end

  `LLJD_ASSERT_NEXT(a_accept_dispatch, clk_i, rst_ni, in_valid_i && !in_stall_o, state_q == S_DISP)
  `LLJD_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, out_vld_q && out_stall_i, !fin)
  `LLJD_ASSERT_NOW(a_idle_has_result, clk_i, rst_ni, $fell(in_stall_o), out_vld_q)

endmodule

### rtl/least_loaded_job_dispatcher.sv
// Top level of the least-loaded job dispatcher: controller plus datapath.
// Depends on lljd_pkg, lljd_ctrl and lljd_dp.
//
//   Channel | Dir | Handshake                | Fields
//   --------+-----+--------------------------+----------------------------------------
//   in      | in  | in_valid_i / in_stall_o  | req_type, server_id, work_units
//   out     | out | out_valid_o / out_stall_i| chosen_server, load_after, units_moved,
//           |     |                          | now_enabled, status
//
// One item is handled at a time. Each scan reads the load memory one server
// per cycle; a submit or a refused toggle needs one scan.
// A toggle that moves work runs one more scan per unit moved;
// the single read port of the load memory sets the pace of each scan.
// After each result the controller returns to idle, where the next item is taken.
// Reset enables every server; loads read as zero through per-entry valid bits,
// so no clearing pass is needed. A finished item waits in the output register
// while the next item is taken; a stalled output holds only the final step.
module least_loaded_job_dispatcher #(
  parameter int NUM_SERVERS = lljd_pkg::NUM_SERVERS_DEF,
  parameter int LOAD_BITS   = lljd_pkg::LOAD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            req_type_i,
  input  logic [lljd_pkg::SID_W-1:0]      server_id_i,
  input  logic [lljd_pkg::WORK_W-1:0]     work_units_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [lljd_pkg::SID_W-1:0]      chosen_server_o,
  output logic [lljd_pkg::OUT_W-1:0]      load_after_o,
  output logic [lljd_pkg::OUT_W-1:0]      units_moved_o,
  output logic                            now_enabled_o,
  output logic [lljd_pkg::STATUS_W-1:0]   status_o
);
  import lljd_pkg::*;

  // Commands flow from the controller to the datapath; status flows back.
  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller owns the handshakes and the item sequence: dispatch,
  // scan, evaluate, and for toggles a check-scan-move loop per unit.
  lljd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the loads, enable bits, scan accumulators and the
  // result register that drives the output fields.
  lljd_dp #(
    .NUM_SERVERS (NUM_SERVERS),
    .LOAD_BITS   (LOAD_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_type_i      (req_type_i),
    .server_id_i     (server_id_i),
    .work_units_i    (work_units_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .chosen_server_o (chosen_server_o),
    .load_after_o    (load_after_o),
    .units_moved_o   (units_moved_o),
    .now_enabled_o   (now_enabled_o),
    .status_o        (status_o)
  );

endmodule
